FILE: rtl/core/antialiased_line_stepper_defines.svh
// Assertion macros for the antialiased line stepper.
`ifndef ANTIALIASED_LINE_STEPPER_DEFINES_SVH
`define ANTIALIASED_LINE_STEPPER_DEFINES_SVH
`ifndef SYNTHESIS
// Checks a property on every rising clock edge outside of reset.
`define ALS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("antialiased_line_stepper: property violated");
// Checks that a condition never holds outside of reset.
`define ALS_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("antialiased_line_stepper: forbidden condition seen");
`else
`define ALS_ASSERT(lbl, clk, rst_n, prop)
`define ALS_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

FILE: rtl/core/als_pkg.sv
`default_nettype none

package als_pkg;

    // Fixed field widths of the port words.
    localparam int COORD_BITS     = 16;
    localparam int WEIGHT_BITS    = 8;
    localparam int CFG_BITS       = 16;
    localparam int CFG_INDEX_BITS = 1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_HEIGHT = 1'b1;

    // Frame size after reset.
    localparam logic [CFG_BITS-1:0] FRAME_WIDTH_RESET  = 16'd640;
    localparam logic [CFG_BITS-1:0] FRAME_HEIGHT_RESET = 16'd480;

    // Action codes of an input word.
    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_STEP = 1'b1;

    // Input word.
    typedef struct packed {
        logic                          action;
        logic signed [COORD_BITS-1:0]  start_x;
        logic signed [COORD_BITS-1:0]  start_y;
        logic signed [COORD_BITS-1:0]  end_x;
        logic signed [COORD_BITS-1:0]  end_y;
    } t_in_word;

    // Output word.
    typedef struct packed {
        logic signed [COORD_BITS-1:0]  pixel_x;
        logic signed [COORD_BITS-1:0]  pixel_y;
        logic                          neighbour_on_y;
        logic [WEIGHT_BITS:0]          first_weight;
        logic [WEIGHT_BITS-1:0]        second_weight;
        logic                          first_inside;
        logic                          second_inside;
        logic                          last_step;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic div_step;
        logic div_last;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_load;
        logic degenerate;
        logic out_busy;
    } t_status;

    // True when a pixel with sign-extended coordinates lies in the frame.
    function automatic logic pixel_inside(
        input logic [COORD_BITS:0] x,
        input logic [COORD_BITS:0] y,
        input logic [CFG_BITS-1:0] width,
        input logic [CFG_BITS-1:0] height
    );
        logic x_ok;
        logic y_ok;
        x_ok = !x[COORD_BITS] && (x[COORD_BITS-1:0] < width);
        y_ok = !y[COORD_BITS] && (y[COORD_BITS-1:0] < height);
        return x_ok && y_ok;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/als_ctrl.sv
`default_nettype none

module als_ctrl #(
    parameter int FRACTION_BITS = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  wire                  i_out_stall,
    input  wire als_pkg::t_status i_status,
    output als_pkg::t_cmd        o_cmd
);

    localparam int CNT_BITS = $clog2(FRACTION_BITS + 1);

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_DIVIDE = 1'b1;

    logic                r_state;
    logic                n_state;
    logic [CNT_BITS-1:0] r_count;
    logic [CNT_BITS-1:0] n_count;
    logic                w_out_free;
    logic                w_accept;

    // A word is taken only when idle and the output register can take a result.
    assign w_out_free = !i_status.out_busy || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !w_out_free;
    assign w_accept   = i_in_valid && !o_in_stall;

    // Sequencing: a load with distinct endpoints runs one quotient bit a cycle.
    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        o_cmd          = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = w_accept && i_status.is_load;
                o_cmd.step = w_accept && !i_status.is_load;
                if (w_accept && i_status.is_load && !i_status.degenerate) begin
                    n_state = S_DIVIDE;
                    n_count = '0;
                end
            end
            S_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                o_cmd.div_last = (r_count == CNT_BITS'(FRACTION_BITS));
                n_count        = r_count + CNT_BITS'(1);
                if (o_cmd.div_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/als_datapath.sv
`default_nettype none

module als_datapath #(
    parameter int FRACTION_BITS = 16
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire [als_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  wire [als_pkg::CFG_BITS-1:0]         i_cfg_data,
    input  wire als_pkg::t_in_word              i_in_word,
    input  wire                                 i_out_stall,
    output logic                                o_out_valid,
    output als_pkg::t_out_word                  o_out_word,
    input  wire als_pkg::t_cmd                  i_cmd,
    output als_pkg::t_status                    o_status
);

    localparam int C  = als_pkg::COORD_BITS;
    localparam int W  = als_pkg::WEIGHT_BITS;
    localparam int F  = FRACTION_BITS;
    localparam int DW = C + 1;          // endpoint differences
    localparam int MW = C + F + 1;      // minor position in fixed point
    localparam int IW = F + 2;          // minor increment

    // Frame size.
    logic [als_pkg::CFG_BITS-1:0] r_frame_width;
    logic [als_pkg::CFG_BITS-1:0] r_frame_height;

    // Line state.
    logic [C-1:0]  r_major;
    logic [MW-1:0] r_minor;
    logic [IW-1:0] r_inc;
    logic [C:0]    r_steps;
    logic          r_dir_neg;
    logic          r_x_minor;
    logic          r_active;

    // Slope divider state.
    logic [C-1:0]  r_div_rem;
    logic [C-1:0]  r_div_den;
    logic [F:0]    r_div_bits;
    logic [F:0]    r_div_quo;
    logic          r_div_neg;

    // Output register.
    logic               r_out_valid;
    als_pkg::t_out_word r_out_word;

    // Load geometry.
    logic [DW-1:0] w_dx;
    logic [DW-1:0] w_dy;
    logic [DW-1:0] w_ndx;
    logic [DW-1:0] w_ndy;
    logic [C-1:0]  w_adx;
    logic [C-1:0]  w_ady;
    logic          w_x_major;
    logic [C-1:0]  w_amaj;
    logic [C-1:0]  w_amin;
    logic          w_min_neg;
    logic          w_maj_neg;
    logic [C-1:0]  w_smaj;
    logic [C-1:0]  w_smin;
    logic          w_degenerate;

    // Divider iteration.
    logic [C:0]    w_trial;
    logic          w_ge;
    logic [C:0]    w_diff;
    logic [F:0]    w_quo_next;
    logic [IW-1:0] w_quo_ext;

    // Step outputs.
    logic [C:0]    w_floor;
    logic [C:0]    w_floor_p1;
    logic [F-1:0]  w_frac;
    logic [W-1:0]  w_w2;
    logic [W:0]    w_w1;
    logic [C:0]    w_major_ext;
    logic [C:0]    w_px;
    logic [C:0]    w_py;
    logic [C:0]    w_qx;
    logic [C:0]    w_qy;
    logic          w_last;
    logic          w_emit;

    // Endpoint differences and major axis choice.
    assign w_dx  = {i_in_word.end_x[C-1], i_in_word.end_x}
                 - {i_in_word.start_x[C-1], i_in_word.start_x};
    assign w_dy  = {i_in_word.end_y[C-1], i_in_word.end_y}
                 - {i_in_word.start_y[C-1], i_in_word.start_y};
    assign w_ndx = -w_dx;
    assign w_ndy = -w_dy;
    assign w_adx = w_dx[DW-1] ? w_ndx[C-1:0] : w_dx[C-1:0];
    assign w_ady = w_dy[DW-1] ? w_ndy[C-1:0] : w_dy[C-1:0];

    assign w_x_major    = (w_adx >= w_ady);
    assign w_amaj       = w_x_major ? w_adx : w_ady;
    assign w_amin       = w_x_major ? w_ady : w_adx;
    assign w_maj_neg    = w_x_major ? w_dx[DW-1] : w_dy[DW-1];
    assign w_min_neg    = w_x_major ? w_dy[DW-1] : w_dx[DW-1];
    assign w_smaj       = w_x_major ? i_in_word.start_x : i_in_word.start_y;
    assign w_smin       = w_x_major ? i_in_word.start_y : i_in_word.start_x;
    assign w_degenerate = (w_dx == '0) && (w_dy == '0);

    // One restoring division step: quotient bits come out MSB first.
    assign w_trial    = {r_div_rem, r_div_bits[F]};
    assign w_ge       = (w_trial >= {1'b0, r_div_den});
    assign w_diff     = w_trial - {1'b0, r_div_den};
    assign w_quo_next = {r_div_quo[F-1:0], w_ge};
    assign w_quo_ext  = r_div_neg ? -{1'b0, w_quo_next} : {1'b0, w_quo_next};

    // Floor and fraction of the minor position.
    assign w_floor    = r_minor[MW-1:F];
    assign w_floor_p1 = w_floor + (C+1)'(1);
    assign w_frac     = r_minor[F-1:0];

    generate
        if (F >= W) begin : g_weight_shr
            assign w_w2 = w_frac[F-1 -: W];
        end else begin : g_weight_shl
            assign w_w2 = {w_frac, {(W-F){1'b0}}};
        end
    endgenerate

    assign w_w1 = {1'b1, {W{1'b0}}} - {1'b0, w_w2};

    // Pixel pair coordinates.
    assign w_major_ext = {r_major[C-1], r_major};
    assign w_px = r_x_minor ? w_floor     : w_major_ext;
    assign w_py = r_x_minor ? w_major_ext : w_floor;
    assign w_qx = r_x_minor ? w_floor_p1  : w_major_ext;
    assign w_qy = r_x_minor ? w_major_ext : w_floor_p1;
    assign w_last = (r_steps <= (C+1)'(1));
    assign w_emit = i_cmd.step && r_active;

    // Status for the controller.
    assign o_status.is_load    = (i_in_word.action == als_pkg::ACTION_LOAD);
    assign o_status.degenerate = w_degenerate;
    assign o_status.out_busy   = r_out_valid;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Control registers: frame size, line activity, step count, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= als_pkg::FRAME_WIDTH_RESET;
            r_frame_height <= als_pkg::FRAME_HEIGHT_RESET;
            r_active       <= 1'b0;
            r_steps        <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    als_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                    als_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.load) begin
                r_active <= !w_degenerate;
                r_steps  <= w_degenerate ? '0 : {1'b0, w_amaj};
            end else if (w_emit) begin
                r_active <= !w_last;
                r_steps  <= w_last ? '0 : r_steps - (C+1)'(1);
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Line geometry, divider and result word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !w_degenerate) begin
            r_major    <= w_smaj;
            r_minor    <= {w_smin[C-1], w_smin, {F{1'b0}}};
            r_dir_neg  <= w_maj_neg;
            r_x_minor  <= !w_x_major;
            r_div_rem  <= {1'b0, w_amin[C-1:1]};
            r_div_bits <= {w_amin[0], {F{1'b0}}};
            r_div_den  <= w_amaj;
            r_div_quo  <= '0;
            r_div_neg  <= w_min_neg;
        end else if (w_emit) begin
            r_major <= r_dir_neg ? r_major - C'(1) : r_major + C'(1);
            r_minor <= r_minor + {{(MW-IW){r_inc[IW-1]}}, r_inc};
        end
        if (i_cmd.div_step) begin
            r_div_rem  <= w_ge ? w_diff[C-1:0] : w_trial[C-1:0];
            r_div_bits <= {r_div_bits[F-1:0], 1'b0};
            r_div_quo  <= w_quo_next;
        end
        if (i_cmd.div_last) begin
            r_inc <= w_quo_ext;
        end
        if (w_emit) begin
            r_out_word.pixel_x        <= w_px[C-1:0];
            r_out_word.pixel_y        <= w_py[C-1:0];
            r_out_word.neighbour_on_y <= !r_x_minor;
            r_out_word.first_weight   <= w_w1;
            r_out_word.second_weight  <= w_w2;
            r_out_word.first_inside   <= als_pkg::pixel_inside(w_px, w_py,
                                             r_frame_width, r_frame_height);
            r_out_word.second_inside  <= als_pkg::pixel_inside(w_qx, w_qy,
                                             r_frame_width, r_frame_height);
            r_out_word.last_step      <= w_last;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/antialiased_line_stepper.sv
// Step word: with a line active, the result is registered and valid in the
// cycle after acceptance; one step word per cycle while output is not stalled.
// Load word: the input is stalled while the one-bit-per-cycle slope divider
// runs; a load with equal endpoints does not start the divider.
// Reset (synchronous, active low) drops any line and sets the frame to 640x480.
`default_nettype none
`include "antialiased_line_stepper_defines.svh"

module antialiased_line_stepper #(
    parameter int FRACTION_BITS = 16
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire [als_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  wire [als_pkg::CFG_BITS-1:0]         i_cfg_data,
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire als_pkg::t_in_word              i_in_word,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output als_pkg::t_out_word                  o_out_word
);

    als_pkg::t_cmd    w_cmd;
    als_pkg::t_status w_status;

    // Sequencer for word acceptance and slope division.
    als_ctrl #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Line state, divider and result register.
    als_datapath #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_in_word),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_cmd       (w_cmd),
        .o_status    (w_status)
    );

    // Division never overlaps with taking a word.
    `ALS_ASSERT_NEVER(a_div_no_accept, i_clk, i_rst_n, w_cmd.div_step && (w_cmd.load || w_cmd.step))
    // A load with distinct endpoints blocks the input while the slope is divided.
    `ALS_ASSERT(a_load_blocks, i_clk, i_rst_n, w_cmd.load && !w_status.degenerate |=> o_in_stall)
    // A step is taken only when the output register can hold its result.
    `ALS_ASSERT(a_step_has_room, i_clk, i_rst_n, w_cmd.step |-> (!o_out_valid || !i_out_stall))

endmodule

`default_nettype wire

FILE: tb/sv/antialiased_line_stepper_test.sv
`default_nettype none

module antialiased_line_stepper_test;

    localparam int FRAC_BITS = 16;
    localparam longint FRAC_ONE = longint'(1) << FRAC_BITS;

    // Run shape.
    localparam int DRAIN_CYCLES     = 40;
    localparam int IDLE_LIMIT       = 3000;
    localparam int HOLD_AT          = 500;
    localparam int HOLD_CYCLES      = 400;
    localparam int RANDOM_PER_PHASE = 95;
    localparam int MAX_LINE_STEPS   = 48;
    localparam int PHASES           = 7;

    // How a stimulus row is checked.
    localparam int ROW_PREDICT = 0;
    localparam int ROW_NONE    = 1;
    localparam int ROW_WORD    = 2;

    typedef struct {
        als_pkg::t_in_word  w;
        int                 kind;
        als_pkg::t_out_word want;
    } t_stim_row;

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               cfg_we;
    logic [als_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [als_pkg::CFG_BITS-1:0]       cfg_data;
    logic                               in_valid;
    logic                               in_stall;
    als_pkg::t_in_word                  in_word;
    logic                               out_valid;
    logic                               out_stall;
    als_pkg::t_out_word                 out_word;

    // Line state as the stepper should hold it.
    longint    pos_major;
    longint    pos_minor_fx;
    longint    minor_step_fx;
    longint    steps_left;
    bit        major_backward;
    bit        minor_is_x;
    bit        line_live;
    longint    frame_w;
    longint    frame_h;

    als_pkg::t_out_word pending_pairs[$];
    t_stim_row          directed_rows[$];
    int        mismatches = 0;
    int        words_counted = 0;
    int        burst_left = 0;
    int        idle_cycles = 0;

    antialiased_line_stepper #(
        .FRACTION_BITS(FRAC_BITS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    // Free-running clock, period 8.
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint clamp16(input longint v);
        if (v < -32768) begin
            return -32768;
        end
        if (v > 32767) begin
            return 32767;
        end
        return v;
    endfunction

    function automatic bit pixel_in_frame(input longint x, input longint y);
        return x >= 0 && y >= 0 && x < frame_w && y < frame_h;
    endfunction

    function automatic als_pkg::t_in_word mk_word(input bit action, input longint sx,
                                                  input longint sy, input longint ex,
                                                  input longint ey);
        als_pkg::t_in_word w;
        w.action  = action;
        w.start_x = sx[als_pkg::COORD_BITS-1:0];
        w.start_y = sy[als_pkg::COORD_BITS-1:0];
        w.end_x   = ex[als_pkg::COORD_BITS-1:0];
        w.end_y   = ey[als_pkg::COORD_BITS-1:0];
        return w;
    endfunction

    // Step words carry random coordinates, which the block must ignore.
    function automatic als_pkg::t_in_word mk_step();
        return mk_word(als_pkg::ACTION_STEP, $urandom, $urandom, $urandom, $urandom);
    endfunction

    function automatic als_pkg::t_out_word mk_pair(input longint px, input longint py,
                                          input bit ny, input int w1, input int w2,
                                          input bit fi, input bit si, input bit last);
        als_pkg::t_out_word r;
        r.pixel_x        = px[als_pkg::COORD_BITS-1:0];
        r.pixel_y        = py[als_pkg::COORD_BITS-1:0];
        r.neighbour_on_y = ny;
        r.first_weight   = w1[als_pkg::WEIGHT_BITS:0];
        r.second_weight  = w2[als_pkg::WEIGHT_BITS-1:0];
        r.first_inside   = fi;
        r.second_inside  = si;
        r.last_step      = last;
        return r;
    endfunction

    // Advances the line state by one input word and returns 1 when the word
    // yields a pixel pair, which is placed in r.
    function automatic bit next_pixel_pair(input als_pkg::t_in_word w,
                                           output als_pkg::t_out_word r);
        longint sx, sy, ex, ey, dx, dy, adx, ady;
        longint dmaj, dmin, smaj, smin, amaj;
        longint mfloor, w2, px, py, qx, qy;
        bit     last;
        r = '0;
        if (w.action == als_pkg::ACTION_LOAD) begin
            sx = $signed(w.start_x);
            sy = $signed(w.start_y);
            ex = $signed(w.end_x);
            ey = $signed(w.end_y);
            dx = ex - sx;
            dy = ey - sy;
            adx = mag(dx);
            ady = mag(dy);
            if (dx == 0 && dy == 0) begin
                line_live = 1'b0;
                steps_left = 0;
                return 1'b0;
            end
            if (adx >= ady) begin
                minor_is_x = 1'b0;
                dmaj = dx; dmin = dy; smaj = sx; smin = sy; amaj = adx;
            end else begin
                minor_is_x = 1'b1;
                dmaj = dy; dmin = dx; smaj = sy; smin = sx; amaj = ady;
            end
            major_backward = dmaj < 0;
            pos_major = smaj;
            pos_minor_fx = smin * FRAC_ONE;
            // Signed division truncates toward zero.
            minor_step_fx = (dmin * FRAC_ONE) / amaj;
            steps_left = amaj;
            line_live = 1'b1;
            return 1'b0;
        end
        if (!line_live) begin
            return 1'b0;
        end

        // Arithmetic shift gives a true floor for negative positions too.
        mfloor = pos_minor_fx >>> FRAC_BITS;
        w2 = (pos_minor_fx & (FRAC_ONE - 1)) >> (FRAC_BITS - als_pkg::WEIGHT_BITS);
        if (minor_is_x) begin
            px = mfloor; py = pos_major; qx = px + 1; qy = py;
        end else begin
            px = pos_major; py = mfloor; qx = px; qy = py + 1;
        end
        last = steps_left <= 1;
        r = mk_pair(px, py, !minor_is_x,
                    int'((longint'(1) << als_pkg::WEIGHT_BITS) - w2),
                    int'(w2), pixel_in_frame(px, py), pixel_in_frame(qx, qy), last);

        pos_major += major_backward ? -1 : 1;
        pos_minor_fx += minor_step_fx;
        if (last) begin
            steps_left = 0;
            line_live = 1'b0;
        end else begin
            steps_left--;
        end
        return 1'b1;
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endfunction

    function automatic string pair_text(input als_pkg::t_out_word p);
        return $sformatf("x=%0d y=%0d ny=%0b w=%0d/%0d in=%0b%0b last=%0b",
                         p.pixel_x, p.pixel_y, p.neighbour_on_y, p.first_weight,
                         p.second_weight, p.first_inside, p.second_inside, p.last_step);
    endfunction

    // Offers one word; the sender runs in bursts with random gaps between them.
    task automatic send_word(input als_pkg::t_in_word w, input int kind,
                             input als_pkg::t_out_word want);
        int                 gap;
        bit                 has;
        als_pkg::t_out_word r;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);

        // The word was taken at this edge.
        has = next_pixel_pair(w, r);
        if (kind == ROW_WORD) begin
            pending_pairs.push_back(want);
        end else if (kind == ROW_PREDICT && has) begin
            pending_pairs.push_back(r);
        end
        if (w.action == als_pkg::ACTION_LOAD || has) begin
            words_counted++;
        end
    endtask

    // Loads a line and steps along it; a cut line may be left before its end.
    task automatic run_line(input longint sx, input longint sy, input longint ex,
                            input longint ey, input int extra, input bit cut);
        longint len;
        int     n;
        len = (mag(ex - sx) > mag(ey - sy)) ? mag(ex - sx) : mag(ey - sy);
        n = (len > MAX_LINE_STEPS) ? $urandom_range(1, MAX_LINE_STEPS) : int'(len);
        if (cut) begin
            n = $urandom_range(0, n);
        end
        n += extra;
        send_word(mk_word(als_pkg::ACTION_LOAD, sx, sy, ex, ey), ROW_PREDICT, '0);
        repeat (n) send_word(mk_step(), ROW_PREDICT, '0);
    endtask

    // Waits until every pair has come back and any slope division is done.
    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_pairs.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_frame(input longint w, input longint h);
        cfg_we    <= 1'b1;
        cfg_index <= als_pkg::CFG_FRAME_WIDTH;
        cfg_data  <= w[als_pkg::CFG_BITS-1:0];
        @(posedge clk);
        cfg_index <= als_pkg::CFG_FRAME_HEIGHT;
        cfg_data  <= h[als_pkg::CFG_BITS-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        frame_w = w & 16'hFFFF;
        frame_h = h & 16'hFFFF;
    endtask

    // Coordinates cluster at the range ends, the frame edges and near zero.
    function automatic longint pick_coord(input longint size);
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 3))
                    0: return -32768;
                    1: return -1;
                    2: return 0;
                    default: return 32767;
                endcase
            end
            1: return longint'($signed(16'($urandom)));
            2: return clamp16(size - 3 + $urandom_range(0, 5));
            default: return longint'($urandom_range(0, 60)) - 10;
        endcase
    endfunction

    function automatic longint pick_delta();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return longint'($urandom_range(0, 65535)) - 32768;
            default: return longint'($urandom_range(0, 64)) - 32;
        endcase
    endfunction

    function automatic void add_row(input als_pkg::t_in_word w, input int kind,
                                    input als_pkg::t_out_word want);
        t_stim_row row;
        row.w = w;
        row.kind = kind;
        row.want = want;
        directed_rows.push_back(row);
    endfunction

    // Receiver stall pattern, with one long hold-off that fills the block.
    initial begin : stall_pattern
        int cycle_no;
        int hold_left;
        int mode;
        int mode_left;
        int run_left;
        bit run_val;
        cycle_no = 0;
        hold_left = 0;
        mode = 0;
        mode_left = 0;
        run_left = 0;
        run_val = 1'b0;
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            cycle_no++;
            if (cycle_no == HOLD_AT) begin
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= $urandom_range(0, 1);
                    2: out_stall <= ($urandom_range(0, 3) == 0);
                    default: begin
                        if (run_left == 0) begin
                            run_val = !run_val;
                            run_left = $urandom_range(1, 8);
                        end
                        run_left--;
                        out_stall <= run_val;
                    end
                endcase
            end
        end
    end

    // Result checking and the no-progress watchdog.
    always @(posedge clk) begin : result_check
        als_pkg::t_out_word want;
        string              bad;
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end else if (out_valid && !out_stall) begin
                if (pending_pairs.size() == 0) begin
                    note_mismatch({"unexpected word ", pair_text(out_word)});
                end else begin
                    want = pending_pairs.pop_front();
                    bad = "";
                    if (out_word.pixel_x !== want.pixel_x) bad = {bad, " pixel_x"};
                    if (out_word.pixel_y !== want.pixel_y) bad = {bad, " pixel_y"};
                    if (out_word.neighbour_on_y !== want.neighbour_on_y)
                        bad = {bad, " neighbour_on_y"};
                    if (out_word.first_weight !== want.first_weight)
                        bad = {bad, " first_weight"};
                    if (out_word.second_weight !== want.second_weight)
                        bad = {bad, " second_weight"};
                    if (out_word.first_inside !== want.first_inside)
                        bad = {bad, " first_inside"};
                    if (out_word.second_inside !== want.second_inside)
                        bad = {bad, " second_inside"};
                    if (out_word.last_step !== want.last_step)
                        bad = {bad, " last_step"};
                    if (bad != "") begin
                        note_mismatch($sformatf("fields%s: expected %s, got %s", bad,
                                                pair_text(want), pair_text(out_word)));
                    end
                end
            end
        end
    end

    initial begin : stimulus
        longint sx, sy, ex, ey;
        int     phase_base;
        longint phase_w[PHASES];
        longint phase_h[PHASES];

        phase_w = '{640, 1, 32768, 0, 65535, 65535, 0};
        phase_h = '{480, 1, 32768, 65535, 0, 65535, 0};

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = als_pkg::CFG_FRAME_WIDTH;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_word   = '0;

        // Predictor state after reset.
        pos_major = 0;
        pos_minor_fx = 0;
        minor_step_fx = 0;
        steps_left = 0;
        major_backward = 1'b0;
        minor_is_x = 1'b0;
        line_live = 1'b0;
        frame_w = als_pkg::FRAME_WIDTH_RESET;
        frame_h = als_pkg::FRAME_HEIGHT_RESET;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words, all on the 640x480 frame left by reset.
        // A step with no line loaded is ignored.
        add_row(mk_step(), ROW_NONE, '0);
        // Horizontal two-pixel line; the end point is not drawn.
        add_row(mk_word(als_pkg::ACTION_LOAD, 0, 0, 2, 0), ROW_NONE, '0);
        add_row(mk_step(), ROW_WORD, mk_pair(0, 0, 1, 256, 0, 1, 1, 0));
        add_row(mk_step(), ROW_WORD, mk_pair(1, 0, 1, 256, 0, 1, 1, 1));
        add_row(mk_step(), ROW_NONE, '0);
        // Equal endpoints leave the line empty.
        add_row(mk_word(als_pkg::ACTION_LOAD, 5, 5, 5, 5), ROW_NONE, '0);
        add_row(mk_step(), ROW_NONE, '0);
        // Half-pixel slope splits the weight evenly on the second step.
        add_row(mk_word(als_pkg::ACTION_LOAD, 0, 0, 2, 1), ROW_NONE, '0);
        add_row(mk_step(), ROW_WORD, mk_pair(0, 0, 1, 256, 0, 1, 1, 0));
        add_row(mk_step(), ROW_WORD, mk_pair(1, 0, 1, 128, 128, 1, 1, 1));
        // Diagonal towards smaller x and y, crossing below zero.
        add_row(mk_word(als_pkg::ACTION_LOAD, 3, 0, 0, -3), ROW_NONE, '0);
        add_row(mk_step(), ROW_PREDICT, '0);
        add_row(mk_step(), ROW_PREDICT, '0);
        add_row(mk_step(), ROW_PREDICT, '0);
        // Steep line running backwards, with a fractional negative slope.
        add_row(mk_word(als_pkg::ACTION_LOAD, 0, 0, -1, -3), ROW_NONE, '0);
        add_row(mk_step(), ROW_PREDICT, '0);
        add_row(mk_step(), ROW_PREDICT, '0);
        // Full-range diagonals, each cut short by the next load.
        add_row(mk_word(als_pkg::ACTION_LOAD, -32768, -32768, 32767, 32767),
                ROW_NONE, '0);
        add_row(mk_step(), ROW_WORD, mk_pair(-32768, -32768, 1, 256, 0, 0, 0, 0));
        add_row(mk_word(als_pkg::ACTION_LOAD, 32767, 32767, -32768, -32768),
                ROW_NONE, '0);
        add_row(mk_step(), ROW_WORD, mk_pair(32767, 32767, 1, 256, 0, 0, 0, 0));
        // Vertical line on the last column: the neighbour falls off the frame.
        add_row(mk_word(als_pkg::ACTION_LOAD, 639, 479, 639, 0), ROW_NONE, '0);
        add_row(mk_step(), ROW_WORD, mk_pair(639, 479, 0, 256, 0, 1, 0, 0));
        add_row(mk_word(als_pkg::ACTION_LOAD, 100, 100, 99, 105), ROW_NONE, '0);
        add_row(mk_step(), ROW_PREDICT, '0);

        foreach (directed_rows[i]) begin
            send_word(directed_rows[i].w, directed_rows[i].kind, directed_rows[i].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            if (p != 0) begin
                drain();
                if (p == PHASES - 1) begin
                    write_frame($urandom_range(1, 1024), $urandom_range(1, 1024));
                end else begin
                    write_frame(phase_w[p], phase_h[p]);
                end
            end

            // Lines hugging the top of the coordinate range, so that the
            // neighbour lies one past it.
            run_line(32767, 10, 32767, 13, 0, 1'b0);
            run_line(10, 32767, 13, 32767, 0, 1'b0);

            // Mostly whole lines with random content, some cut short,
            // some empty, and a little noise.
            phase_base = words_counted;
            while (words_counted < phase_base + RANDOM_PER_PHASE) begin
                sx = pick_coord(frame_w);
                sy = pick_coord(frame_h);
                ex = clamp16(sx + pick_delta());
                ey = clamp16(sy + pick_delta());
                case ($urandom_range(0, 9))
                    0: send_word(mk_word($urandom_range(0, 1), $urandom, $urandom,
                                         $urandom, $urandom), ROW_PREDICT, '0);
                    1: run_line(sx, sy, sx, sy, $urandom_range(0, 3), 1'b0);
                    2: run_line(sx, sy, ex, ey, 0, 1'b1);
                    default: run_line(sx, sy, ex, ey,
                                      ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0,
                                      1'b0);
                endcase
            end
        end

        drain();
        if (pending_pairs.size() != 0) begin
            note_mismatch($sformatf("%0d expected words never arrived",
                                    pending_pairs.size()));
        end
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
